### hdl/chunked_body_decoder_defines.svh
// ---------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CBD_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define CBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cbd_pkg.sv
// ---------------------------------------------------------------------------
// Chunked body decoder package
// Widths, character codes, phase and status codes and the hex digit decoder.
// ---------------------------------------------------------------------------
package cbd_pkg;

  // Width of the chunk size, remaining byte and total body counters.
  localparam int COUNT_WIDTH = 32;
  // Width of the size limit register.
  localparam int LIMIT_WIDTH = 32;
  // Width used when comparing counters against the limit.
  localparam int CMP_WIDTH   = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  // Reset value of the size limit.
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1048576);

  // Character codes used by the framing.
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Decoder phase, one-hot.
  typedef enum logic [7:0] {
    PH_SIZE     = 8'b0000_0001,
    PH_SIZE_CR  = 8'b0000_0010,
    PH_DATA     = 8'b0000_0100,
    PH_DATA_CR  = 8'b0000_1000,
    PH_DATA_LF  = 8'b0001_0000,
    PH_DONE     = 8'b0010_0000,
    PH_TOOBIG   = 8'b0100_0000,
    PH_BADFRAME = 8'b1000_0000
  } phase_e;

  // Status reported with every result beat.
  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_DONE     = 2'd1,
    ST_TOOBIG   = 2'd2,
    ST_BADFRAME = 2'd3
  } status_e;

  // Input action codes.
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // True when the character is a hex digit.
  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Value of a hex digit; only meaningful when is_hex() holds.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

### hdl/chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// Chunked body decoder
// Decodes a chunked message body one byte per beat into payload bytes and a
// framing status.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side: one beat per stream byte. tdata carries the byte, tuser is
//   the action (0 = decode the byte, 1 = restart for a new body).
//   Master side: exactly one result beat per input beat. tdata carries the
//   body byte (zero when not payload) and the status above it; tuser is set
//   when the byte is chunk payload.
//   cfg_we_i writes the size limit, which applies to each chunk and to the
//   running body total. Write it only while the decoder is idle.
// Timing:
//   A result appears in the cycle after its input beat is accepted. While
//   the receiver does not stall, one beat is taken every cycle: the whole
//   per-byte update sits between the decoder state and the result register.
// Reset and stalls:
//   Reset returns the decoder to the size line state with zero counters and
//   sets the limit to 1 MiB. While the receiver stalls, the result register
//   holds its beat and s_axis_tready stays low until that beat is taken.
// ---------------------------------------------------------------------------
`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder
  import cbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Size limit register write.
  input  logic                   cfg_we_i,
  input  logic [LIMIT_WIDTH-1:0] cfg_wdata_i,
  // Stream bytes in.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] action
  // Decoded results out.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // [7:0] body_byte, [9:8] status, rest 0
  output logic                   m_axis_tuser    // [0] body_valid
);

  // Limit register and decoder state.
  logic [LIMIT_WIDTH-1:0] limit_q;
  phase_e                 phase_q, phase_d;
  count_t                 accum_q, accum_d;
  logic                   nonempty_q, nonempty_d;
  logic                   has_digit_q, has_digit_d;
  logic                   digits_ended_q, digits_ended_d;
  count_t                 left_q, left_d;
  count_t                 total_q, total_d;

  // Result register.
  logic                   out_valid_q;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_body_q, out_body_d;
  status_e                out_status_q, out_status_d;

  logic                   in_acc;
  logic [7:0]             c;
  logic                   c_hex;
  logic                   c_blank;
  count_t                 accum_shift;
  count_t                 size;
  count_t                 left_dec;
  logic [CMP_WIDTH-1:0]   size_x, total_x, lim_x;
  logic                   too_big;

  // The input side moves whenever the result register is free or emptying.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;

  // Per-byte helpers: hex digit, blank, saturating accumulate, size check.
  always_comb begin
    c_hex   = is_hex(c);
    c_blank = (c == CH_SP) || (c == CH_TAB);
    if (|accum_q[COUNT_WIDTH-1 -: 4]) begin
      accum_shift = '1;
    end else begin
      accum_shift = {accum_q[COUNT_WIDTH-5:0], hex_val(c)};
    end
    size     = has_digit_q ? accum_q : '0;
    left_dec = (left_q != '0) ? (left_q - count_t'(1)) : left_q;
    size_x   = CMP_WIDTH'(size);
    total_x  = CMP_WIDTH'(total_q);
    lim_x    = CMP_WIDTH'(limit_q);
    too_big  = (size_x > lim_x) || (total_x > lim_x) || (size_x > (lim_x - total_x));
  end

  // Next decoder state and result for the byte on the slave side.
  always_comb begin
    phase_d        = phase_q;
    accum_d        = accum_q;
    nonempty_d     = nonempty_q;
    has_digit_d    = has_digit_q;
    digits_ended_d = digits_ended_q;
    left_d         = left_q;
    total_d        = total_q;
    out_byte_d     = 8'h00;
    out_body_d     = 1'b0;

    if (s_axis_tuser == ACT_RESTART) begin
      phase_d        = PH_SIZE;
      accum_d        = '0;
      nonempty_d     = 1'b0;
      has_digit_d    = 1'b0;
      digits_ended_d = 1'b0;
      left_d         = '0;
      total_d        = '0;
    end else begin
      case (phase_q)
        PH_SIZE: begin
          if (c == CH_CR) begin
            phase_d = PH_SIZE_CR;
          end else begin
            nonempty_d = 1'b1;
            if (!digits_ended_q) begin
              if (c_hex) begin
                accum_d     = accum_shift;
                has_digit_d = 1'b1;
              end else if (!(c_blank && !has_digit_q)) begin
                digits_ended_d = 1'b1;
              end
            end
          end
        end
        PH_SIZE_CR: begin
          if (c == CH_LF) begin
            // End of the size line.
            accum_d        = '0;
            nonempty_d     = 1'b0;
            has_digit_d    = 1'b0;
            digits_ended_d = 1'b0;
            if (!nonempty_q) begin
              phase_d = PH_SIZE;
            end else if (size == '0) begin
              phase_d = PH_DONE;
            end else if (too_big) begin
              phase_d = PH_TOOBIG;
            end else begin
              total_d = total_q + size;
              left_d  = size;
              phase_d = PH_DATA;
            end
          end else begin
            // A lone CR is an ordinary non-hex byte, so the digits end there.
            nonempty_d     = 1'b1;
            digits_ended_d = 1'b1;
            phase_d        = (c == CH_CR) ? PH_SIZE_CR : PH_SIZE;
          end
        end
        PH_DATA: begin
          out_byte_d = c;
          out_body_d = 1'b1;
          left_d     = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          phase_d = (c == CH_CR) ? PH_DATA_LF : PH_BADFRAME;
        end
        PH_DATA_LF: begin
          if (c == CH_LF) begin
            accum_d        = '0;
            nonempty_d     = 1'b0;
            has_digit_d    = 1'b0;
            digits_ended_d = 1'b0;
            phase_d        = PH_SIZE;
          end else begin
            phase_d = PH_BADFRAME;
          end
        end
        default: begin
          // Done and error phases hold until a restart.
        end
      endcase
    end

    case (phase_d)
      PH_DONE:     out_status_d = ST_DONE;
      PH_TOOBIG:   out_status_d = ST_TOOBIG;
      PH_BADFRAME: out_status_d = ST_BADFRAME;
      default:     out_status_d = ST_BUSY;
    endcase
  end

  // Size limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Decoder state, updated on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SIZE;
      accum_q        <= '0;
      nonempty_q     <= 1'b0;
      has_digit_q    <= 1'b0;
      digits_ended_q <= 1'b0;
      left_q         <= '0;
      total_q        <= '0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      accum_q        <= accum_d;
      nonempty_q     <= nonempty_d;
      has_digit_q    <= has_digit_d;
      digits_ended_q <= digits_ended_d;
      left_q         <= left_d;
      total_q        <= total_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_byte_q   <= out_byte_d;
      out_body_q   <= out_body_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_status_q, out_byte_q};
  assign m_axis_tuser  = out_body_q;

  // Checks on the decoder's own logic.
  `CBD_ASSERT(a_body_busy, !(out_valid_q && out_body_q) || (out_status_q == ST_BUSY), "payload beat with non-busy status")
  `CBD_ASSERT(a_data_left, (phase_q != PH_DATA) || (left_q != '0), "data phase with no bytes left")
  `CBD_ASSERT_NEXT(a_sticky, in_acc && (s_axis_tuser == ACT_BYTE) && ((phase_q == PH_DONE) || (phase_q == PH_TOOBIG) || (phase_q == PH_BADFRAME)), phase_q == $past(phase_q), "terminal phase left without restart")
  `CBD_ASSERT_NEXT(a_restart, in_acc && (s_axis_tuser == ACT_RESTART), (phase_q == PH_SIZE) && (total_q == '0) && !out_body_q, "restart did not clear the decoder")

endmodule

### sim/cbd_checker.sv
// ---------------------------------------------------------------------------
// Chunked body decoder result checker
// Watches the stream and limit write ports of the decoder, keeps its own
// model of the decoder state, queues the expected result of every accepted
// input beat and compares each accepted result beat with the oldest one.
// ---------------------------------------------------------------------------
module cbd_checker
  import cbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LIMIT_WIDTH-1:0] cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [7:0]             s_axis_tdata_i,
  input  logic                   s_axis_tuser_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [15:0]            m_axis_tdata_i,
  input  logic                   m_axis_tuser_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o
);

  localparam count_t COUNT_FULL = '1;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    status_e    status;
  } decoded_t;

  // Results still owed by the decoder, oldest first.
  decoded_t decoded_q[$];
  int unsigned fails;

  // Model of the decoder state and of the size limit register.
  logic [LIMIT_WIDTH-1:0] size_limit;
  phase_e                 phase;
  count_t                 size_accum;
  count_t                 bytes_left;
  count_t                 body_total;
  logic                   line_nonempty;
  logic                   line_has_digit;
  logic                   line_digits_done;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - int'(8'h30);
    end else if (c >= "a" && c <= "f") begin
      return int'(c) - int'(8'h61) + 10;
    end else if (c >= "A" && c <= "F") begin
      return int'(c) - int'(8'h41) + 10;
    end
    return -1;
  endfunction

  function automatic void clear_size_line();
    size_accum       = '0;
    line_nonempty    = 1'b0;
    line_has_digit   = 1'b0;
    line_digits_done = 1'b0;
  endfunction

  function automatic void restart_decoder();
    phase = PH_SIZE;
    clear_size_line();
    bytes_left = '0;
    body_total = '0;
  endfunction

  // One character of a size line. Digits accumulate with saturation; blanks
  // before the first digit are skipped and anything else ends the digits.
  function automatic void take_line_char(logic [7:0] c);
    int d;
    d = hex_digit(c);
    line_nonempty = 1'b1;
    if (line_digits_done) begin
      return;
    end
    if (d >= 0) begin
      if (size_accum > ((COUNT_FULL - count_t'(d)) >> 4)) begin
        size_accum = COUNT_FULL;
      end else begin
        size_accum = (size_accum << 4) + count_t'(d);
      end
      line_has_digit = 1'b1;
    end else if (line_has_digit || (c != CH_SP && c != CH_TAB)) begin
      line_digits_done = 1'b1;
    end
  endfunction

  // CR LF closing a size line: skip an empty line, stop on size zero, check
  // the chunk and the running total against the limit, else enter the data.
  function automatic void finish_size_line();
    count_t      chunk;
    logic [63:0] lim;
    logic [63:0] tot;
    logic [63:0] sz;
    if (!line_nonempty) begin
      clear_size_line();
      phase = PH_SIZE;
      return;
    end
    chunk = line_has_digit ? size_accum : '0;
    clear_size_line();
    if (chunk == '0) begin
      phase = PH_DONE;
      return;
    end
    lim = 64'(size_limit);
    tot = 64'(body_total);
    sz  = 64'(chunk);
    if (sz > lim || tot > lim || sz > lim - tot) begin
      phase = PH_TOOBIG;
      return;
    end
    body_total = body_total + chunk;
    bytes_left = chunk;
    phase      = PH_DATA;
  endfunction

  // Advances the model by one input beat and returns the result it causes.
  function automatic decoded_t decode_beat(logic act, logic [7:0] c);
    decoded_t r;
    r.body_byte  = '0;
    r.body_valid = 1'b0;
    if (act == ACT_RESTART) begin
      restart_decoder();
    end else begin
      case (phase)
        PH_SIZE: begin
          if (c == CH_CR) begin
            phase = PH_SIZE_CR;
          end else begin
            take_line_char(c);
          end
        end
        PH_SIZE_CR: begin
          if (c == CH_LF) begin
            finish_size_line();
          end else begin
            // A CR without LF is an ordinary line character.
            take_line_char(CH_CR);
            if (c == CH_CR) begin
              phase = PH_SIZE_CR;
            end else begin
              take_line_char(c);
              phase = PH_SIZE;
            end
          end
        end
        PH_DATA: begin
          r.body_byte  = c;
          r.body_valid = 1'b1;
          if (bytes_left != '0) begin
            bytes_left = bytes_left - 1'b1;
          end
          if (bytes_left == '0) begin
            phase = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          if (c == CH_CR) begin
            phase = PH_DATA_LF;
          end else begin
            phase = PH_BADFRAME;
          end
        end
        PH_DATA_LF: begin
          if (c == CH_LF) begin
            clear_size_line();
            phase = PH_SIZE;
          end else begin
            phase = PH_BADFRAME;
          end
        end
        default: begin
          // Done and error phases hold until a restart.
        end
      endcase
    end
    case (phase)
      PH_DONE:     r.status = ST_DONE;
      PH_TOOBIG:   r.status = ST_TOOBIG;
      PH_BADFRAME: r.status = ST_BADFRAME;
      default:     r.status = ST_BUSY;
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: result beat with no expected result, expected none, got tdata %0h tuser %0b",
               $time, m_axis_tdata_i, m_axis_tuser_i);
      fails++;
      return;
    end
    want = decoded_q.pop_front();
    compare_field("body_byte", want.body_byte, m_axis_tdata_i[7:0]);
    compare_field("status", 8'(want.status), 8'(m_axis_tdata_i[9:8]));
    compare_field("tdata padding", 8'h00, 8'(m_axis_tdata_i[15:10]));
    compare_field("body_valid", 8'(want.body_valid), 8'(m_axis_tuser_i));
  endfunction

  // Results are compared before new beats are queued: a result accepted at
  // an edge always belongs to an input beat taken at an earlier edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_decoder();
      size_limit = LIMIT_RESET;
      decoded_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (cfg_we_i) begin
        size_limit = cfg_wdata_i;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_result();
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        decoded_q.push_back(decode_beat(s_axis_tuser_i, s_axis_tdata_i));
      end
      pending_o    <= decoded_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### sim/tb_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// Chunked body decoder testbench
// Feeds the decoder a short directed sequence and then random chunked bodies,
// broken framing and noise under several size limits and idling patterns on
// both stream sides. A checker beside the decoder predicts every result beat.
// ---------------------------------------------------------------------------
module tb_chunked_body_decoder;
  import cbd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int BEATS_PER_PHASE = 100;
  localparam int LIMIT_PHASES    = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [LIMIT_WIDTH-1:0] cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // [7:0] data_byte
  logic                   s_axis_tuser;   // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [15:0]            m_axis_tdata;   // [7:0] body_byte, [9:8] status, rest 0
  logic                   m_axis_tuser;   // [0] body_valid

  int unsigned            pending;
  int unsigned            fail_count;
  int unsigned            sender_idle_pct;
  int unsigned            receiver_stall_pct;
  int unsigned            beats_sent;
  int unsigned            quiet_cycles;
  logic [LIMIT_WIDTH-1:0] size_limit;

  always #5 clk_i = ~clk_i;

  chunked_body_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cbd_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Receiver: stalls at random at the rate of the current idling phase.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] d, logic upper);
    if (d < 4'd10) begin
      return 8'h30 + 8'(d);
    end else if (upper) begin
      return 8'h41 + 8'(d) - 8'd10;
    end
    return 8'h61 + 8'(d) - 8'd10;
  endfunction

  // Sends one input beat, idling first at the current rate, and returns at
  // the edge that accepts it with tvalid still high.
  task automatic send_beat(logic act, logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_crlf();
    send_beat(ACT_BYTE, CH_CR);
    send_beat(ACT_BYTE, CH_LF);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_beat(ACT_BYTE, s[i]);
    end
  endtask

  // Size line: optional blanks, hex digits in mixed case, an optional
  // extension with arbitrary bytes, then CR LF. Size zero may come out as a
  // line with no digits at all.
  task automatic send_size_line(logic [63:0] size);
    int digits;
    int i;
    digits = 1;
    while (digits < 16 && (size >> (4 * digits)) != 0) begin
      digits++;
    end
    repeat ($urandom_range(0, 2)) begin
      send_beat(ACT_BYTE, ($urandom_range(1) != 0) ? CH_SP : CH_TAB);
    end
    if (size != 0 || $urandom_range(3) != 0) begin
      if ($urandom_range(4) == 0) begin
        send_beat(ACT_BYTE, hex_char(4'h0, 1'b0));
      end
      for (i = digits - 1; i >= 0; i--) begin
        send_beat(ACT_BYTE, hex_char(size[4*i +: 4], 1'($urandom_range(1))));
      end
    end
    if ($urandom_range(4) == 0) begin
      send_beat(ACT_BYTE, ";");
      repeat ($urandom_range(0, 3)) send_beat(ACT_BYTE, 8'($urandom));
    end
    send_crlf();
  endtask

  // One body after a restart: a few chunks, mostly well formed, with sizes
  // at and over the limit, huge sizes, stray empty lines and broken CR LF,
  // then the zero chunk and perhaps a trailer, unless a long size ends it early.
  task automatic send_body();
    logic [63:0] size;
    send_beat(ACT_RESTART, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(9) == 0) begin
        send_crlf();
      end
      case ($urandom_range(19))
        0:       size = 64'(size_limit) + 64'd1;
        1:       size = 64'(size_limit);
        2:       size = {32'($urandom_range(1, 16'hFFFF)), 32'($urandom)};
        default: size = 64'($urandom_range(1, 12));
      endcase
      send_size_line(size);
      // Sizes too long to stream out end the body early; the next one restarts.
      if (size > 64'd40) begin
        repeat ($urandom_range(0, 3)) send_beat(ACT_BYTE, 8'($urandom));
        return;
      end
      repeat (size) send_beat(ACT_BYTE, 8'($urandom));
      case ($urandom_range(19))
        0: send_beat(ACT_BYTE, 8'($urandom));
        1: begin
          send_beat(ACT_BYTE, CH_CR);
          send_beat(ACT_BYTE, 8'($urandom));
        end
        default: send_crlf();
      endcase
    end
    send_size_line(64'd0);
    if ($urandom_range(1) != 0) begin
      send_text("X-Sum: ");
      repeat ($urandom_range(1, 4)) send_beat(ACT_BYTE, 8'($urandom));
      send_crlf();
    end
    send_crlf();
  endtask

  // Raw noise, with the odd restart among it.
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      send_beat(($urandom_range(7) == 0) ? ACT_RESTART : ACT_BYTE, 8'($urandom));
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
      default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
    endcase
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_WIDTH-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    size_limit   = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [LIMIT_WIDTH-1:0] limit_plan [LIMIT_PHASES];
    int p;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_BYTE;
    quiet_cycles  <= 0;
    beats_sent     = 0;
    size_limit     = LIMIT_RESET;
    set_idling(0);
    limit_plan[0] = '0;
    limit_plan[1] = LIMIT_WIDTH'(48);
    limit_plan[2] = '1;
    limit_plan[3] = LIMIT_WIDTH'(20);
    limit_plan[4] = LIMIT_WIDTH'(1);
    limit_plan[5] = LIMIT_WIDTH'(300);
    limit_plan[6] = LIMIT_WIDTH'($urandom_range(8, 200));
    limit_plan[7] = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset limit: an empty line, blanks and an
    // extension, extreme payload bytes, a lone CR in a line without digits
    // that ends the body, a byte after done, and a missing CR LF after data.
    send_beat(ACT_RESTART, 8'hFF);
    send_crlf();
    send_text(" \t2;");
    send_crlf();
    send_beat(ACT_BYTE, 8'h00);
    send_beat(ACT_BYTE, 8'hFF);
    send_crlf();
    send_beat(ACT_BYTE, CH_CR);
    send_text("z");
    send_crlf();
    send_text("T");
    send_beat(ACT_RESTART, 8'h00);
    send_text("1");
    send_crlf();
    send_text("qX");

    // Random part: one size limit per phase, idling patterns in rotation.
    for (p = 0; p < LIMIT_PHASES; p++) begin
      write_limit(limit_plan[p]);
      set_idling(p % 4);
      while (beats_sent < (p + 1) * BEATS_PER_PHASE) begin
        if ($urandom_range(9) == 0) begin
          send_noise();
        end else begin
          send_body();
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/cbd_pkg.sv
hdl/chunked_body_decoder.sv
sim/cbd_checker.sv
sim/tb_chunked_body_decoder.sv
